// ----- sv/mrsnt_pkg.sv -----
// ----------------------------------------------------------------------------
// MIDI running-status note tracker - shared package
// Constants, the status length table, state encodings and the request struct
// that passes between the framer and the note store.
// ----------------------------------------------------------------------------
package mrsnt_pkg;

  localparam int NOTES_PER_CHANNEL = 8;
  localparam int CHANNEL_COUNT     = 16;

  localparam int CH_W   = 4;
  localparam int IDX_W  = (NOTES_PER_CHANNEL > 1) ? $clog2(NOTES_PER_CHANNEL) : 1;
  localparam int CNT_W  = $clog2(NOTES_PER_CHANNEL + 1);
  localparam int DEPTH  = CHANNEL_COUNT * NOTES_PER_CHANNEL;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [7:0] REALTIME_MIN = 8'hF8;
  localparam logic [3:0] KIND_NOTE_ON = 4'h9;
  localparam logic [3:0] KIND_CC      = 4'hB;
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [7:0] CC_OFF_MIN   = 8'h7B;
  localparam logic [7:0] CC_OFF_MAX   = 8'h7F;

  // Message length of system status bytes F0..FF.
  localparam logic [1:0] SYS_LEN [16] = '{
    2'd0, 2'd2, 2'd3, 2'd2, 2'd0, 2'd0, 2'd1, 2'd0,
    2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BYTES,
    ST_OFFS
  } emit_state_t;

  typedef enum logic [1:0] {
    OFF_STATUS,
    OFF_NOTE,
    OFF_VEL
  } off_step_t;

  typedef struct packed {
    logic            push;
    logic            clear;
    logic [CH_W-1:0] ch;
    logic [6:0]      note;
  } store_req_t;

  function automatic logic [1:0] len_of(input logic [7:0] b);
    logic [1:0] len;
    case (b) inside
      [8'h00:8'h7F]: len = 2'd0;
      [8'h80:8'hBF]: len = 2'd3;
      [8'hC0:8'hDF]: len = 2'd2;
      [8'hE0:8'hEF]: len = 2'd3;
      default:       len = SYS_LEN[b[3:0]];
    endcase
    return len;
  endfunction

endpackage

// ----- sv/mrsnt_note_store.sv -----
// ----------------------------------------------------------------------------
// MIDI running-status note tracker - note store
// Per-channel ring of held notes in a synchronous RAM, with per-channel fill
// count and next-slot pointer in flops.
// ----------------------------------------------------------------------------
module mrsnt_note_store (
  input  logic                        clk,
  input  logic                        rst,
  input  mrsnt_pkg::store_req_t       req,
  output logic [mrsnt_pkg::CNT_W-1:0] count,
  input  logic [mrsnt_pkg::CH_W-1:0]  rd_ch,
  input  logic [mrsnt_pkg::IDX_W-1:0] rd_idx,
  output logic [6:0]                  rd_note
);
  import mrsnt_pkg::*;

  logic [6:0]       note_ram [DEPTH];
  logic [CNT_W-1:0] fill     [CHANNEL_COUNT];
  logic [IDX_W-1:0] next_slot[CHANNEL_COUNT];
  logic [IDX_W-1:0] slot;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign count   = fill[req.ch];
  assign slot    = next_slot[req.ch];
  assign wr_addr = ADDR_W'(req.ch) * ADDR_W'(NOTES_PER_CHANNEL) + ADDR_W'(slot);
  assign rd_addr = ADDR_W'(rd_ch) * ADDR_W'(NOTES_PER_CHANNEL) + ADDR_W'(rd_idx);

  always_ff @(posedge clk) begin
    if (req.push) begin
      note_ram[wr_addr] <= req.note;
    end
    rd_note <= note_ram[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        fill[c]      <= '0;
        next_slot[c] <= '0;
      end
    end else if (req.clear) begin
      fill[req.ch]      <= '0;
      next_slot[req.ch] <= '0;
    end else if (req.push) begin
      // wrap the ring; the oldest note is overwritten once full
      if (slot == IDX_W'(NOTES_PER_CHANNEL - 1)) begin
        next_slot[req.ch] <= '0;
      end else begin
        next_slot[req.ch] <= slot + IDX_W'(1);
      end
      if (count != CNT_W'(NOTES_PER_CHANNEL)) begin
        fill[req.ch] <= count + CNT_W'(1);
      end
    end
  end

endmodule

// ----- sv/midi_running_status_note_tracker.sv -----
// ----------------------------------------------------------------------------
// MIDI running-status note tracker - top level
// Frames a raw MIDI byte stream into whole messages, keeps running status and
// optionally replaces all-notes-off controllers with explicit Note Offs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_byte) takes one raw MIDI byte per
//   request. Output channel (out_valid/out_ready/out_byte/last_of_run) gives
//   the bytes that request causes, one per cycle unless out_ready stalls;
//   last_of_run marks the final one. A byte that completes no message gives
//   no output, unless it is a realtime byte or one with no message length.
//   The request is registered into the emitter, which then loads each output
//   byte into the output register. Normal traffic gives 1 to 3 output bytes,
//   an all-notes-off with eight held notes up to 24 (three bytes per Note
//   Off, each note read from the store RAM before its note byte). in_ready
//   is high whenever the emitter is idle, which includes the cycles where
//   the last byte of a run still waits in the output register.
//   A stall on out_ready holds the output register and freezes the emitter;
//   nothing is dropped. Reset clears running status, the framer position,
//   all per-channel fill counts and the tracking enable. The note RAM is not
//   cleared: empty slots are never read. cfg_write/cfg_data set the tracking
//   enable, by the user only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module midi_running_status_note_tracker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run
);
  import mrsnt_pkg::*;

  // configuration
  logic fake_notes_off_enable;

  // framer state
  logic [7:0] running_status;
  logic [1:0] message_length;
  logic [1:0] message_position;
  logic [7:0] message_bytes [3];

  // emitter state
  emit_state_t      state, state_next;
  logic [7:0]       emit_buf [3];
  logic [1:0]       emit_len;
  logic [1:0]       emit_idx;
  logic [CH_W-1:0]  off_ch;
  logic [CNT_W-1:0] off_count;
  logic [IDX_W-1:0] note_idx;
  off_step_t        off_step;

  // accept-time decode
  logic            accept;
  logic            is_realtime;
  logic [7:0]      rs_n;
  logic [1:0]      len_n;
  logic [1:0]      pos_n;
  logic [1:0]      pos_inc;
  logic [1:0]      pos_upd;
  logic [7:0]      mb_n [3];
  logic            complete;
  logic            plan_bytes;
  logic            plan_offs;
  logic [7:0]      buf_n [3];
  logic [1:0]      buf_len_n;
  store_req_t      req;
  logic [CNT_W-1:0] store_count;
  logic [6:0]      store_note;

  // emitter outputs
  logic       load;
  logic       emit_fire;
  logic [7:0] emit_byte;
  logic       emit_last;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign load     = !out_valid || out_ready;

  // Decode one byte: update framer, decide what (if anything) to send.
  always_comb begin
    is_realtime = (in_byte >= REALTIME_MIN);
    rs_n       = in_byte[7] ? in_byte : running_status;
    len_n      = in_byte[7] ? len_of(in_byte) : message_length;
    pos_n      = in_byte[7] ? 2'd0 : message_position;
    pos_inc    = pos_n + 2'd1;
    mb_n       = message_bytes;
    if (pos_n != 2'd3) begin
      mb_n[pos_n] = in_byte;
    end
    complete   = (len_n != 2'd0) && (pos_inc >= len_n);
    pos_upd    = complete ? 2'd1 : pos_inc;
    if (len_n == 2'd0) begin
      pos_upd = pos_n;
    end

    req        = '0;
    req.ch     = rs_n[3:0];
    req.note   = mb_n[1][6:0];
    plan_bytes = 1'b0;
    plan_offs  = 1'b0;
    buf_n      = mb_n;
    buf_len_n  = len_n;

    if (is_realtime || len_n == 2'd0) begin
      // pass the byte through alone
      plan_bytes = 1'b1;
      buf_n[0]   = in_byte;
      buf_len_n  = 2'd1;
    end else if (complete) begin
      plan_bytes = 1'b1;
      if (fake_notes_off_enable) begin
        if (rs_n[7:4] == KIND_NOTE_ON) begin
          req.push = accept && (mb_n[2] != 8'h00);
        end else if (rs_n[7:4] == KIND_CC && mb_n[1] >= CC_OFF_MIN &&
                     mb_n[1] <= CC_OFF_MAX) begin
          // drop the controller; send held notes off instead
          plan_bytes = 1'b0;
          plan_offs  = (store_count != '0);
          req.clear  = accept;
        end
      end
    end
  end

  mrsnt_note_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .count   (store_count),
    .rd_ch   (off_ch),
    .rd_idx  (note_idx),
    .rd_note (store_note)
  );

  // Emitter: one output byte per cycle whenever the output register is free.
  always_comb begin
    state_next = state;
    emit_fire  = 1'b0;
    emit_byte  = emit_buf[emit_idx];
    emit_last  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && plan_bytes) begin
          state_next = ST_BYTES;
        end else if (accept && plan_offs) begin
          state_next = ST_OFFS;
        end
      end
      ST_BYTES: begin
        emit_fire = load;
        emit_byte = emit_buf[emit_idx];
        emit_last = (emit_idx == emit_len - 2'd1);
        if (load && emit_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_OFFS: begin
        emit_fire = load;
        case (off_step)
          OFF_STATUS: emit_byte = {KIND_NOTE_OFF, off_ch};
          OFF_NOTE:   emit_byte = {1'b0, store_note};
          OFF_VEL:    emit_byte = 8'h00;
          default:    emit_byte = 8'h00;
        endcase
        emit_last = (off_step == OFF_VEL) &&
                    (CNT_W'(note_idx) == off_count - CNT_W'(1));
        if (load && emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fake_notes_off_enable <= 1'b0;
    end else if (cfg_write) begin
      fake_notes_off_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_status   <= '0;
      message_length   <= '0;
      message_position <= '0;
    end else if (accept && !is_realtime) begin
      running_status   <= rs_n;
      message_length   <= len_n;
      message_position <= pos_upd;
    end
  end

  // message bytes carry no reset; only written entries are ever read
  always_ff @(posedge clk) begin
    if (accept && !is_realtime) begin
      message_bytes <= mb_n;
    end
  end

  // emitter bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      emit_buf  <= buf_n;
      emit_len  <= buf_len_n;
      emit_idx  <= 2'd0;
      off_ch    <= rs_n[3:0];
      off_count <= store_count;
      note_idx  <= '0;
      off_step  <= OFF_STATUS;
    end else if (emit_fire) begin
      if (state == ST_BYTES) begin
        emit_idx <= emit_idx + 2'd1;
      end else begin
        case (off_step)
          OFF_STATUS: off_step <= OFF_NOTE;
          OFF_NOTE:   off_step <= OFF_VEL;
          default: begin
            off_step <= OFF_STATUS;
            note_idx <= note_idx + IDX_W'(1);
          end
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_byte    <= emit_byte;
      last_of_run <= emit_last;
    end
  end

endmodule

// ----- sv/mrsnt_checker.sv -----
// ----------------------------------------------------------------------------
// MIDI running-status note tracker - port checker
// Watches the top-level ports for handshake and sequencing rules.
// ----------------------------------------------------------------------------
module mrsnt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_of_run
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run))
    else $error("stalled output changed");

  // no new request while a run is still being delivered
  a_run_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> !in_ready)
    else $error("input taken in the middle of a run");

  // a realtime byte always produces output, so the emitter is busy next cycle
  a_realtime_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_byte[7:3] == 5'h1F |=> !in_ready)
    else $error("realtime byte produced no output");

  // reset leaves the output channel empty
  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind midi_running_status_note_tracker mrsnt_checker u_mrsnt_checker (.*);

// ----- test/tb_midi_running_status_note_tracker.sv -----
// ----------------------------------------------------------------------------
// MIDI running-status note tracker - self-checking testbench
// Streams raw MIDI bytes through the framer with random gaps and output stalls.
// A behavioral copy of the framer and the note store predicts every byte, and
// the monitor compares each output byte in order. Tracking is switched off and
// on between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_midi_running_status_note_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import mrsnt_pkg::*;

  localparam int STALL_LIMIT = 3000;  // cycles with no request moving
  localparam int DRAIN_WAIT  = 40;    // longest run plus margin
  localparam int LONG_HOLD   = 300;   // one long receiver hold-off
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } synth_byte_t;

  // Plain running-status traffic with tracking off.
  localparam logic [7:0] WARMUP [18] = '{
    8'hF8, 8'h00, 8'hF0, 8'hF7, 8'h90, 8'h3C, 8'h40, 8'hF6, 8'h55,
    8'hF1, 8'h20, 8'h21, 8'hC5, 8'h7F, 8'hB0, 8'h7B, 8'h00, 8'hFF
  };
  // Tracking on: two held notes, a zero-velocity Note On, then all-notes-off
  // on a loaded channel and on an empty one.
  localparam logic [7:0] TRACKED [13] = '{
    8'h91, 8'h40, 8'h7F, 8'h41, 8'h01, 8'h42, 8'h00,
    8'hB1, 8'h7B, 8'h00, 8'hB2, 8'h7C, 8'h00
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       last_of_run;

  midi_running_status_note_tracker dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last_of_run(last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predicted framer state
  // --------------------------------------------------------------------------
  logic       track_on = 1'b0;
  logic [7:0] rs_status = 8'h00;
  logic [1:0] rs_len = 2'd0;
  logic [1:0] rs_pos = 2'd0;
  logic [7:0] msg_bytes [3];
  logic [6:0] held_notes [CHANNEL_COUNT][NOTES_PER_CHANNEL];
  int         held_count [CHANNEL_COUNT];
  int         next_slot [CHANNEL_COUNT];

  logic [7:0]  run_bytes [$];        // bytes caused by the current request
  synth_byte_t synth_bytes_due [$];  // bytes the synthesizer side still owes
  logic [7:0]  host_bytes [$];       // requests waiting for the driver

  // Bookkeeping.
  int  queued;
  int  requests_taken = 0;
  int  bytes_checked = 0;
  int  offs_runs = 0;
  int  longest_run = 0;
  int  mismatches = 0;
  int  stall_cycles = 0;
  bit  in_took = 1'b0;
  bit  calm = 1'b0;
  bit  long_hold_go = 1'b0;
  bit  long_hold_used = 1'b0;
  int  hold_left = 0;
  int  gap_left = 0;
  int  stall_left = 0;

  function automatic logic [1:0] status_len(input logic [7:0] b);
    if (!b[7]) return 2'd0;
    if (b[7:6] == 2'b10) return 2'd3;   // note off, note on, aftertouch, CC
    if (b[7:5] == 3'b110) return 2'd2;  // program change, channel pressure
    if (b[7:4] == 4'hE) return 2'd3;    // pitch bend
    return SYS_LEN[b[3:0]];
  endfunction

  // Advance the predicted framer by one host byte and queue what it causes.
  task automatic frame_midi_byte(input logic [7:0] b);
    logic [3:0]  kind;
    logic [3:0]  ch;
    logic        fwd;
    int          slot;
    synth_byte_t item;
    run_bytes.delete();
    if (b >= REALTIME_MIN) begin
      // Realtime bytes cut through and leave the framer alone.
      run_bytes.push_back(b);
    end else begin
      if (b[7]) begin
        rs_status = b;
        rs_pos    = 2'd0;
        rs_len    = status_len(b);
      end
      if (rs_len == 2'd0) begin
        run_bytes.push_back(b);
      end else begin
        if (rs_pos < 2'd3) msg_bytes[rs_pos] = b;
        rs_pos = rs_pos + 2'd1;
        if (rs_pos >= rs_len) begin
          kind = rs_status[7:4];
          ch   = rs_status[3:0];
          fwd  = 1'b1;
          if (track_on) begin
            if (kind == KIND_NOTE_ON) begin
              // Store sounding notes only; the ring overwrites its oldest slot.
              if (msg_bytes[2] != 8'h00) begin
                slot = next_slot[ch];
                held_notes[ch][slot] = msg_bytes[1][6:0];
                next_slot[ch] = (slot + 1 >= NOTES_PER_CHANNEL) ? 0 : slot + 1;
                if (held_count[ch] < NOTES_PER_CHANNEL) held_count[ch]++;
              end
            end else if (kind == KIND_CC && msg_bytes[1] >= CC_OFF_MIN &&
                         msg_bytes[1] <= CC_OFF_MAX) begin
              // Drop the controller, send one Note Off per held slot in order.
              fwd = 1'b0;
              for (int i = 0; i < held_count[ch]; i++) begin
                run_bytes.push_back({KIND_NOTE_OFF, ch});
                run_bytes.push_back({1'b0, held_notes[ch][i]});
                run_bytes.push_back(8'h00);
              end
              if (held_count[ch] > 0) offs_runs++;
              held_count[ch] = 0;
              next_slot[ch]  = 0;
            end
          end
          if (fwd) begin
            for (int i = 0; i < rs_len; i++) run_bytes.push_back(msg_bytes[i]);
          end
          rs_pos = 2'd1;
        end
      end
    end
    for (int i = 0; i < run_bytes.size(); i++) begin
      item.data = run_bytes[i];
      item.last = (i == run_bytes.size() - 1);
      synth_bytes_due.push_back(item);
    end
    if (run_bytes.size() > longest_run) longest_run = run_bytes.size();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b);
    host_bytes.push_back(b);
    queued++;
  endtask

  // Queue one short musical phrase, mostly well formed, sometimes noise.
  task automatic queue_phrase();
    int         pick;
    int         n;
    logic [3:0] ch;
    logic [7:0] st;
    pick = int'($urandom_range(0, 99));
    if ($urandom_range(0, 3) == 0) ch = 4'($urandom_range(0, 15));
    else ch = 4'($urandom_range(0, 3));
    if (pick < 45) begin
      // Note Ons, often on running status, sometimes with realtime mixed in.
      if ($urandom_range(0, 3) != 0) queue_byte({KIND_NOTE_ON, ch});
      n = int'($urandom_range(1, NOTES_PER_CHANNEL + 3));
      repeat (n) begin
        queue_byte(8'($urandom_range(0, 127)));
        if ($urandom_range(0, 9) == 0) queue_byte(8'($urandom_range(REALTIME_MIN, 255)));
        if ($urandom_range(0, 5) == 0) queue_byte(8'h00);
        else queue_byte(8'($urandom_range(1, 127)));
      end
    end else if (pick < 65) begin
      // Controller: mostly all-notes-off class, the rest ordinary.
      queue_byte({KIND_CC, ch});
      if ($urandom_range(0, 3) != 0) queue_byte(8'($urandom_range(CC_OFF_MIN, CC_OFF_MAX)));
      else queue_byte(8'($urandom_range(0, 127)));
      queue_byte(8'($urandom_range(0, 127)));
    end else if (pick < 78) begin
      // Any channel message with its proper data count.
      st = 8'($urandom_range(8'h80, 8'hEF));
      queue_byte(st);
      queue_byte(8'($urandom_range(0, 127)));
      if (status_len(st) == 2'd3) queue_byte(8'($urandom_range(0, 127)));
    end else if (pick < 90) begin
      // System common and sysex.
      st = 8'($urandom_range(8'hF0, 8'hF7));
      queue_byte(st);
      n = (st == 8'hF0) ? int'($urandom_range(1, 4)) : int'($urandom_range(0, 3));
      repeat (n) queue_byte(8'($urandom_range(0, 127)));
      if (st == 8'hF0) queue_byte(8'hF7);
    end else begin
      // Noise: any byte at all.
      repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Wait until nothing is in flight, then give the block time to go quiet.
  task automatic settle();
    do @(posedge clk);
    while (host_bytes.size() != 0 || in_valid || synth_bytes_due.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_tracking(input logic v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    track_on  = v;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer host bytes at the falling edge; hold each until taken.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_took) begin
        // hold the request and its byte
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (!calm && host_bytes.size() > 0 && $urandom_range(0, 7) == 0) begin
        gap_left = int'($urandom_range(1, 14)) - 1;
        in_valid <= 1'b0;
      end else if (host_bytes.size() > 0) begin
        in_valid <= 1'b1;
        in_byte  <= host_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off to back up the input.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst) begin
      if (long_hold_go && !long_hold_used) begin
        long_hold_used = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = int'($urandom_range(1, 14)) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on every taken request, check every taken output byte,
  // and watch for a stuck handshake.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    synth_byte_t due;
    in_took = !rst && in_valid && in_ready;
    if (in_took) begin
      frame_midi_byte(in_byte);
      requests_taken++;
    end
    if (!rst && out_valid && out_ready) begin
      if (synth_bytes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected byte %02h last %0b, nothing was due",
                   $realtime, out_byte, last_of_run);
      end else begin
        due = synth_bytes_due.pop_front();
        bytes_checked++;
        if (out_byte !== due.data || last_of_run !== due.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: byte exp %02h got %02h, last_of_run exp %0b got %0b",
                     $realtime, due.data, out_byte, due.last, last_of_run);
        end
      end
    end
    // Count only while work is outstanding; any moving request clears it.
    if (!rst && (host_bytes.size() != 0 || in_valid || synth_bytes_due.size() != 0)) begin
      if (in_took || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end else begin
      stall_cycles = 0;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("handshake stuck for %0d cycles, %0d bytes still due",
               stall_cycles, synth_bytes_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      held_count[c] = 0;
      next_slot[c]  = 0;
      for (int s = 0; s < NOTES_PER_CHANNEL; s++) held_notes[c][s] = 7'h00;
    end
    for (int i = 0; i < 3; i++) msg_bytes[i] = 8'h00;

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed: framing with tracking off, then the note store cases.
    write_tracking(1'b0);
    foreach (WARMUP[i]) queue_byte(WARMUP[i]);
    settle();
    write_tracking(1'b1);
    foreach (TRACKED[i]) queue_byte(TRACKED[i]);
    settle();

    // Random with tracking on; hold the receiver off once so the input backs up.
    queued = 0;
    while (queued < 28) queue_phrase();
    @(posedge clk);
    long_hold_go = 1'b1;
    settle();

    // Random with tracking off; held notes must survive untouched.
    write_tracking(1'b0);
    queued = 0;
    while (queued < 14) queue_phrase();
    settle();

    // Final stretch with tracking back on and no idling on either side.
    write_tracking(1'b1);
    calm = 1'b1;
    queued = 0;
    while (queued < 24) queue_phrase();
    settle();

    if (synth_bytes_due.size() != 0) mismatches++;
    $display("ran %0d host requests and checked %0d output bytes", requests_taken,
             bytes_checked);
    $display("%0d all-notes-off runs replaced, longest run %0d bytes, %0d mismatches",
             offs_runs, longest_run, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
